@@ rtl/rvfjp_pkg.sv @@
// Shared types, status codes and constants of the fetch stage with jump predecode.
package rvfjp_pkg;

	localparam int unsigned PcWidth = 64;
	localparam int unsigned HalfWidth = 16;
	localparam int unsigned InstWidth = 32;
	localparam int unsigned StatusWidth = 3;
	localparam int unsigned CauseWidth = 4;

	localparam logic [StatusWidth-1:0] ST_OK = 3'd0;
	localparam logic [StatusWidth-1:0] ST_MISALIGN = 3'd1;
	localparam logic [StatusWidth-1:0] ST_ACCESS = 3'd2;
	localparam logic [StatusWidth-1:0] ST_PAGE = 3'd3;

	localparam logic [CauseWidth-1:0] CAUSE_MISALIGN = 4'd0;
	localparam logic [CauseWidth-1:0] CAUSE_ACCESS = 4'd1;
	localparam logic [CauseWidth-1:0] CAUSE_PAGE = 4'd12;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_REDIRECT = 1'b1;

	localparam logic [1:0] QUAD_C1 = 2'b01;
	localparam logic [1:0] QUAD_FULL = 2'b11;
	localparam logic [2:0] FUNCT3_CJ = 3'b101;
	localparam logic [6:0] OPC_JAL = 7'h6F;

	typedef struct packed {
		logic cmd;
		logic [PcWidth-1:0] target_pc;
		logic [HalfWidth-1:0] low_half;
		logic [StatusWidth-1:0] low_status;
		logic [HalfWidth-1:0] high_half;
		logic [StatusWidth-1:0] high_status;
	} fetch_item_t;

	typedef struct packed {
		logic emit;
		logic pc_load;
		logic [PcWidth-1:0] next_pc;
		logic [InstWidth-1:0] inst;
		logic exc_valid;
		logic [CauseWidth-1:0] exc_cause;
	} step_t;

endpackage

@@ rtl/rvfjp_in_if.sv @@
// Handshake channel that carries fetch and redirect items into the stage.
interface rvfjp_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [rvfjp_pkg::PcWidth-1:0] target_pc;
	logic [rvfjp_pkg::HalfWidth-1:0] low_half;
	logic [rvfjp_pkg::StatusWidth-1:0] low_status;
	logic [rvfjp_pkg::HalfWidth-1:0] high_half;
	logic [rvfjp_pkg::StatusWidth-1:0] high_status;

	modport source(output valid, cmd, target_pc, low_half, low_status, high_half, high_status,
		input ready);
	modport sink(input valid, cmd, target_pc, low_half, low_status, high_half, high_status,
		output ready);
endinterface

@@ rtl/rvfjp_out_if.sv @@
// Handshake channel that carries fetched instructions out of the stage.
interface rvfjp_out_if;
	logic valid;
	logic ready;
	logic [rvfjp_pkg::PcWidth-1:0] inst_pc;
	logic [rvfjp_pkg::InstWidth-1:0] raw_instruction;
	logic exception_valid;
	logic [rvfjp_pkg::CauseWidth-1:0] exception_cause;

	modport source(output valid, inst_pc, raw_instruction, exception_valid, exception_cause,
		input ready);
	modport sink(input valid, inst_pc, raw_instruction, exception_valid, exception_cause,
		output ready);
endinterface

@@ rtl/rvfjp_predecode.sv @@
// Instruction assembly, fetch status resolution and next counter computation for one item.
module rvfjp_predecode (
	input logic [rvfjp_pkg::PcWidth-1:0] pc,
	input rvfjp_pkg::fetch_item_t item,
	output rvfjp_pkg::step_t step
);
	logic take_high;
	logic [rvfjp_pkg::StatusWidth-1:0] status;
	logic [rvfjp_pkg::HalfWidth-1:0] ins_lo;
	logic [rvfjp_pkg::HalfWidth-1:0] ins_hi;
	logic [rvfjp_pkg::InstWidth-1:0] ins;
	logic fault;
	logic good;
	logic [rvfjp_pkg::CauseWidth-1:0] cause;
	logic is_cj;
	logic is_jal;
	logic [11:0] cj_imm;
	logic [20:0] jal_imm;
	logic [rvfjp_pkg::PcWidth-1:0] offset;

	assign take_high = (item.low_status == rvfjp_pkg::ST_OK)
		&& (item.low_half[1:0] == rvfjp_pkg::QUAD_FULL);
	assign status = take_high ? item.high_status : item.low_status;
	assign ins_lo = (item.low_status == rvfjp_pkg::ST_OK) ? item.low_half : '0;
	assign ins_hi = (take_high && item.high_status == rvfjp_pkg::ST_OK) ? item.high_half : '0;
	assign ins = {ins_hi, ins_lo};

	always_comb begin
		fault = 1'b1;
		cause = rvfjp_pkg::CAUSE_MISALIGN;
		unique case (status)
			rvfjp_pkg::ST_MISALIGN: cause = rvfjp_pkg::CAUSE_MISALIGN;
			rvfjp_pkg::ST_ACCESS: cause = rvfjp_pkg::CAUSE_ACCESS;
			rvfjp_pkg::ST_PAGE: cause = rvfjp_pkg::CAUSE_PAGE;
			default: fault = 1'b0;
		endcase
	end

	assign good = fault || (status == rvfjp_pkg::ST_OK);

	assign is_cj = (ins[1:0] == rvfjp_pkg::QUAD_C1) && (ins[15:13] == rvfjp_pkg::FUNCT3_CJ);
	assign is_jal = (ins[6:0] == rvfjp_pkg::OPC_JAL);
	assign cj_imm = {ins[12], ins[8], ins[10:9], ins[6], ins[7], ins[2], ins[11], ins[5:3], 1'b0};
	assign jal_imm = {ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

	always_comb begin
		if (is_cj) begin
			offset = {{(rvfjp_pkg::PcWidth-12){cj_imm[11]}}, cj_imm};
		end else if (is_jal) begin
			offset = {{(rvfjp_pkg::PcWidth-21){jal_imm[20]}}, jal_imm};
		end else if (ins[1:0] == rvfjp_pkg::QUAD_FULL) begin
			offset = rvfjp_pkg::PcWidth'(4);
		end else begin
			offset = rvfjp_pkg::PcWidth'(2);
		end
	end

	always_comb begin
		step.inst = ins;
		step.exc_valid = fault;
		step.exc_cause = fault ? cause : '0;
		step.emit = 1'b0;
		step.pc_load = 1'b0;
		step.next_pc = pc + offset;
		if (item.cmd == rvfjp_pkg::CMD_REDIRECT) begin
			step.pc_load = 1'b1;
			step.next_pc = item.target_pc;
		end else if (pc != '0 && good) begin
			step.emit = 1'b1;
			step.pc_load = 1'b1;
		end
	end
endmodule

@@ rtl/rv_fetch_stage_jump_predecode_core.sv @@
// Top level of the fetch stage: input register, program counter and result register.
// A tick's result is presented from the result register after its item leaves the input register.
// Throughput: one item per cycle when not stalled; each counter update is ready for the next item.
// A held result stalls the input only when the item in the input register also gives a result.
// Reset clears the program counter to zero (idle) and empties both registers.
module rv_fetch_stage_jump_predecode_core (
	input logic clk,
	input logic arst_n,
	rvfjp_in_if.sink req,
	rvfjp_out_if.source rsp
);
	logic valid_s1;
	rvfjp_pkg::fetch_item_t item_s1;
	logic [rvfjp_pkg::PcWidth-1:0] pc_q;
	rvfjp_pkg::step_t step;
	logic slot_free;
	logic advance;
	logic rsp_valid_s2;
	logic [rvfjp_pkg::PcWidth-1:0] inst_pc_s2;
	logic [rvfjp_pkg::InstWidth-1:0] inst_s2;
	logic exc_valid_s2;
	logic [rvfjp_pkg::CauseWidth-1:0] exc_cause_s2;

	rvfjp_predecode u_predecode (
		.pc(pc_q),
		.item(item_s1),
		.step(step)
	);

	assign slot_free = !rsp_valid_s2 || rsp.ready;
	assign advance = valid_s1 && (!step.emit || slot_free);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.cmd <= req.cmd;
			item_s1.target_pc <= req.target_pc;
			item_s1.low_half <= req.low_half;
			item_s1.low_status <= req.low_status;
			item_s1.high_half <= req.high_half;
			item_s1.high_status <= req.high_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (advance && step.pc_load) begin
			pc_q <= step.next_pc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance && step.emit) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			inst_pc_s2 <= pc_q;
			inst_s2 <= step.inst;
			exc_valid_s2 <= step.exc_valid;
			exc_cause_s2 <= step.exc_cause;
		end
	end

	assign rsp.valid = rsp_valid_s2;
	assign rsp.inst_pc = inst_pc_s2;
	assign rsp.raw_instruction = inst_s2;
	assign rsp.exception_valid = exc_valid_s2;
	assign rsp.exception_cause = exc_cause_s2;

	// A redirect that leaves the input register loads its target into the counter.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == rvfjp_pkg::CMD_REDIRECT |=> pc_q == $past(item_s1.target_pc))
		else $error("redirect did not load the program counter");

	// A new result appears only after an item that gives one has left the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_s2) |-> $past(advance && step.emit))
		else $error("result appeared without a producing item");

	// An item never overwrites a result that is still waiting for its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s2 && !rsp.ready |-> !(advance && step.emit))
		else $error("pending result overwritten");

	// The cause is zero whenever no exception is flagged.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s2 && !exc_valid_s2 |-> exc_cause_s2 == '0)
		else $error("cause set without exception");
endmodule
